/* sv/sffp_pkg.sv */
// Shared types, constants and constant functions of the shear flow factor block.
// Holds the coefficient sets, the exponential table generator and the stage record.
// Depends on nothing; every other design and checker file refers to it by scoped names.
package sffp_pkg;

  localparam int FRAC_BITS_DEF   = 12;
  localparam int EXP_DEPTH_DEF   = 256;
  localparam int INT_FRAC        = 24;
  localparam int ACC_W           = 41;
  localparam int IN_W            = 16;
  localparam int OUT_W           = 21;
  localparam int FAC_W           = 21;
  localparam int LATENCY         = 9;
  localparam logic [IN_W-1:0] CFG_RESET = 16'd4096;
  localparam longint SAT_LIM     = (64'sd1 <<< 40) - 64'sd1;
  localparam longint EXP_M1_Q30  = 64'sd395007542;

  // Coefficients scaled by 1e9: [set][power of g][power of h]
  localparam longint RAW [2][6][6] = '{
    '{
      '{64'sd1036000000, 64'sd378100000, -64'sd129800000, -64'sd14770000, 64'sd7365000,
        -64'sd566800},
      '{-64'sd4050000000, 64'sd681700000, 64'sd3060000, -64'sd12890000, 64'sd511600, 64'sd0},
      '{64'sd9711000000, -64'sd1204000000, 64'sd90080000, 64'sd3367000, 64'sd0, 64'sd0},
      '{-64'sd13490000000, 64'sd663200000, -64'sd46410000, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd10210000000, -64'sd109800000, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
      '{-64'sd3194000000, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
    },
    '{
      '{64'sd140300000, 64'sd744800000, -64'sd274400000, 64'sd31410000, -64'sd593200,
        -64'sd70390},
      '{64'sd109800000, -64'sd203000000, 64'sd59160000, -64'sd4833000, 64'sd100600, 64'sd0},
      '{-64'sd104200000, 64'sd26890000, -64'sd5968000, 64'sd265600, 64'sd0, 64'sd0},
      '{64'sd28280000, -64'sd1413000, 64'sd191600, 64'sd0, 64'sd0, 64'sd0},
      '{-64'sd3105000, 64'sd21830, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
      '{64'sd120300, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
    }
  };

  // One record per Horner stage: lane accumulators and the running total
  typedef struct packed {
    logic                   vld;
    logic                   set;
    logic [IN_W-1:0]        g;
    logic [5:0][ACC_W-1:0]  acc;
    logic [ACC_W-1:0]       tot;
  } sffp_hst_t;

  // Round a scaled coefficient onto the internal grid, half away from zero
  function automatic logic [ACC_W-1:0] coef(input int s, input int j, input int i);
    longint n;
    longint q;
    n = RAW[s][j][i];
    if (n < 0) begin
      q = -(((-n) * (64'sd1 <<< INT_FRAC) + 64'sd500000000) / 64'sd1000000000);
    end else begin
      q = (n * (64'sd1 <<< INT_FRAC) + 64'sd500000000) / 64'sd1000000000;
    end
    return q[ACC_W-1:0];
  endfunction

  // exp(-x) in Q30 for x given in Q30 (Taylor series on the fraction, exp(-1) per unit)
  function automatic logic [30:0] exp_entry(input logic [63:0] xq);
    logic [63:0] f;
    logic [63:0] t;
    longint      sum;
    int          n;
    f   = xq & ((64'd1 << 30) - 64'd1);
    t   = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    n   = int'(xq >> 30);
    for (int m = 1; m <= 20; m++) begin
      t = ((t * f) >> 30) / 64'(m);
      if ((m & 1) != 0) sum = sum - longint'(t);
      else              sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    for (int k = 0; k < n; k++) begin
      sum = longint'((64'(sum) * 64'(EXP_M1_Q30) + (64'd1 << 29)) >> 30);
    end
    return sum[30:0];
  endfunction

endpackage

/* sv/shear_flow_factor_poly.sv */
// Top level of the shear flow factor block: input register, six Horner stages,
// the decay table path and the output stages.
// Depends on sffp_pkg, sffp_horner, sffp_exp and sffp_out.
//
// Usage
//   Input: a request is taken at a rising edge with start high and busy low;
//   in_film_thickness is the thickness h in unsigned Q4.12.
//   Result: out_valid is high for one cycle with out_shear_factor (signed Q8.12);
//   the receiver cannot stall.
//   Throughput: one request per cycle, every cycle; results leave in order.
//   A request passes the input register, six Horner stages (one multiply and
//   saturating add per active lane per stage) and two output stages.
//   Configuration: cfg_we with cfg_wdata writes gamma (unsigned Q4.12); write
//   only while no request is in flight. Gamma >= 1 selects the second set.
//   Reset: synchronous, active low; gamma returns to 1.0, all in-flight requests
//   are dropped and busy is high while reset is held. No clearing pass is needed.
module shear_flow_factor_poly #(
  parameter int FRAC_BITS       = sffp_pkg::FRAC_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = sffp_pkg::EXP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [sffp_pkg::IN_W-1:0]         in_film_thickness,
  input  logic                              cfg_we,
  input  logic [sffp_pkg::IN_W-1:0]         cfg_wdata,
  output logic                              out_valid,
  output logic signed [sffp_pkg::OUT_W-1:0] out_shear_factor
);

  localparam int IW = sffp_pkg::IN_W;
  localparam int XW = FRAC_BITS + 3;
  localparam int MW = (XW > IW) ? XW : IW;
  localparam logic [MW-1:0] FIVE = MW'(5) << FRAC_BITS;
  localparam logic [31:0]   ONE  = 32'(1) << FRAC_BITS;

  logic [IW-1:0]       corr_length_ratio_r;
  logic                vld0_r;
  logic [IW-1:0]       h0_r;
  logic [IW-1:0]       g0_r;
  logic                set0_r;
  logic                above0_r;
  logic [XW-1:0]       x0_r;
  logic [IW-1:0]       d0_r;
  logic                above;
  sffp_pkg::sffp_hst_t st [7];
  logic [XW-1:0]       xs [7];
  logic [IW-1:0]       hd_r [6];
  logic                ad_r [6];
  logic [sffp_pkg::FAC_W-1:0] fac;
  logic [sffp_pkg::FAC_W-1:0] fd_r [4];

  assign busy  = !rst_n;
  assign above = MW'(in_film_thickness) > FIVE;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)      corr_length_ratio_r <= sffp_pkg::CFG_RESET;
    else if (cfg_we) corr_length_ratio_r <= cfg_wdata;
  end

  // Take the request
  always_ff @(posedge clk) begin
    h0_r     <= in_film_thickness;
    g0_r     <= corr_length_ratio_r;
    set0_r   <= 32'(corr_length_ratio_r) >= ONE;
    above0_r <= above;
    x0_r     <= above ? XW'(FIVE) : XW'(in_film_thickness);
    d0_r     <= IW'(MW'(in_film_thickness) - FIVE);
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= start && !busy;
  end

  assign st[0].vld = vld0_r;
  assign st[0].set = set0_r;
  assign st[0].g   = g0_r;
  assign st[0].acc = '0;
  assign st[0].tot = '0;
  assign xs[0]     = x0_r;

  // Horner stages
  for (genvar s = 1; s <= 6; s++) begin : g_stage
    sffp_horner #(
      .FRAC_BITS (FRAC_BITS),
      .XW        (XW),
      .MW        (MW),
      .STEP      (s)
    ) u_horner (
      .clk   (clk),
      .rst_n (rst_n),
      .st_i  (st[s-1]),
      .x_i   (xs[s-1]),
      .st_o  (st[s]),
      .x_o   (xs[s])
    );
  end

  // Decay factor path
  sffp_exp #(
    .FRAC_BITS       (FRAC_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk   (clk),
    .d_i   (d0_r),
    .fac_o (fac)
  );

  // Align thickness, branch flag and factor with the last Horner stage
  always_ff @(posedge clk) begin
    hd_r[0] <= h0_r;
    ad_r[0] <= above0_r;
    for (int i = 1; i < 6; i++) begin
      hd_r[i] <= hd_r[i-1];
      ad_r[i] <= ad_r[i-1];
    end
    fd_r[0] <= fac;
    for (int i = 1; i < 4; i++) begin
      fd_r[i] <= fd_r[i-1];
    end
  end

  sffp_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .vld_i            (st[6].vld),
    .tot_i            (st[6].tot),
    .fac_i            (fd_r[3]),
    .above_i          (ad_r[5]),
    .h_i              (hd_r[5]),
    .out_valid        (out_valid),
    .out_shear_factor (out_shear_factor)
  );

endmodule

/* sv/sffp_horner.sv */
// One Horner stage of the shear flow factor polynomial: one step in h per lane
// not yet finished, and one step of the outer evaluation in g (the first stage
// loads its start value). Uses sffp_pkg coefficients and the stage record.
module sffp_horner #(
  parameter int FRAC_BITS = sffp_pkg::FRAC_BITS_DEF,
  parameter int XW        = sffp_pkg::FRAC_BITS_DEF + 3,
  parameter int MW        = 16,
  parameter int STEP      = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sffp_pkg::sffp_hst_t   st_i,
  input  logic [XW-1:0]         x_i,
  output sffp_pkg::sffp_hst_t   st_o,
  output logic [XW-1:0]         x_o
);

  localparam int AW = sffp_pkg::ACC_W;
  localparam int PW = AW + MW;
  localparam int SW = PW + 2;

  sffp_pkg::sffp_hst_t st_r;
  logic [XW-1:0]       x_r;
  logic [AW-1:0]       acc_nxt [6];
  logic [AW-1:0]       tot_nxt;

  // c + a*y, product rounded half away from zero, sum saturated
  function automatic logic [AW-1:0] step_fn(input logic [AW-1:0] c, input logic [AW-1:0] a,
                                            input logic [MW-1:0] y);
    logic [AW-1:0]        m;
    logic [PW-1:0]        p;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] lim;
    m   = a[AW-1] ? AW'(-a) : a;
    p   = (PW'(m) * PW'(y) + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    s   = $signed({2'b00, p});
    if (a[AW-1]) s = -s;
    s   = s + SW'($signed(c));
    lim = SW'(sffp_pkg::SAT_LIM);
    if (s > lim)       return lim[AW-1:0];
    else if (s < -lim) return AW'(-lim);
    else               return s[AW-1:0];
  endfunction

  // Lane j evaluates the polynomial in h that multiplies g to the power j
  for (genvar j = 0; j < 6; j++) begin : g_lane
    localparam logic [AW-1:0] S0C = sffp_pkg::coef(0, j, 5 - j);
    localparam logic [AW-1:0] S1C = sffp_pkg::coef(1, j, 5 - j);
    logic [AW-1:0] a_in;
    if (STEP == 1) begin : g_first
      assign a_in = st_i.set ? S1C : S0C;
    end else begin : g_later
      assign a_in = st_i.acc[j];
    end
    if (j <= 5 - STEP) begin : g_step
      localparam logic [AW-1:0] K0 = sffp_pkg::coef(0, j, 5 - j - STEP);
      localparam logic [AW-1:0] K1 = sffp_pkg::coef(1, j, 5 - j - STEP);
      assign acc_nxt[j] = step_fn(st_i.set ? K1 : K0, a_in, MW'(x_i));
    end else begin : g_hold
      assign acc_nxt[j] = a_in;
    end
  end

  // Outer evaluation in g consumes the lane finished one stage earlier
  if (STEP == 1) begin : g_tot_init
    localparam logic [AW-1:0] T0 = sffp_pkg::coef(0, 5, 0);
    localparam logic [AW-1:0] T1 = sffp_pkg::coef(1, 5, 0);
    assign tot_nxt = st_i.set ? T1 : T0;
  end else begin : g_tot_step
    assign tot_nxt = step_fn(st_i.acc[6 - STEP], st_i.tot, MW'(st_i.g));
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    st_r.set <= st_i.set;
    st_r.g   <= st_i.g;
    st_r.tot <= tot_nxt;
    for (int j = 0; j < 6; j++) begin
      st_r.acc[j] <= acc_nxt[j];
    end
    x_r <= x_i;
    if (!rst_n) st_r.vld <= 1'b0;
    else        st_r.vld <= st_i.vld;
  end

  assign st_o = st_r;
  assign x_o  = x_r;

endmodule

/* sv/sffp_exp.sv */
// Decay factor exp(-0.25*d) for thickness beyond five: table read and linear
// interpolation over two register stages. Uses sffp_pkg::exp_entry for the table.
module sffp_exp #(
  parameter int FRAC_BITS       = sffp_pkg::FRAC_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = sffp_pkg::EXP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic [sffp_pkg::IN_W-1:0]     d_i,
  output logic [sffp_pkg::FAC_W-1:0]    fac_o
);

  localparam int AW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PSW = sffp_pkg::IN_W + $clog2(EXP_TABLE_DEPTH) + 1;
  localparam int FW  = FRAC_BITS + 4;
  localparam int MUW = 31 + FW;

  logic [30:0]     rom [EXP_TABLE_DEPTH + 1];
  logic [PSW-1:0]  pos;
  logic [PSW-1:0]  idx;
  logic            oor;
  logic [AW-1:0]   addr;
  logic [30:0]     a_r;
  logic [30:0]     b_r;
  logic [FW-1:0]   fr_r;
  logic            oor_r;
  logic [MUW-1:0]  dprod;
  logic [30:0]     v;
  logic [sffp_pkg::FAC_W-1:0] fac_nxt;
  logic [sffp_pkg::FAC_W-1:0] fac_r;

  // Table of exp(-4k/DEPTH) in Q30
  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XQ = (64'(k) << 32) / EXP_TABLE_DEPTH;
    assign rom[k] = sffp_pkg::exp_entry(XQ);
  end

  // Table position of d
  assign pos  = PSW'(d_i) * PSW'(EXP_TABLE_DEPTH);
  assign idx  = pos >> FW;
  assign oor  = idx >= PSW'(EXP_TABLE_DEPTH);
  assign addr = oor ? '0 : idx[AW-1:0];

  // Read both neighbours
  always_ff @(posedge clk) begin
    a_r   <= rom[addr];
    b_r   <= rom[addr + AW'(1)];
    fr_r  <= pos[FW-1:0];
    oor_r <= oor;
  end

  // Interpolate (truncating), then round to Q20
  always_comb begin
    if (a_r >= b_r) begin
      dprod = MUW'(a_r - b_r) * MUW'(fr_r);
      v     = a_r - 31'(dprod >> FW);
    end else begin
      dprod = MUW'(b_r - a_r) * MUW'(fr_r);
      v     = a_r + 31'(dprod >> FW);
    end
    fac_nxt = oor_r ? '0 : sffp_pkg::FAC_W'((32'(v) + 32'd512) >> 10);
  end

  always_ff @(posedge clk) begin
    fac_r <= fac_nxt;
  end

  assign fac_o = fac_r;

endmodule

/* sv/sffp_out.sv */
// Output stages: apply the decay beyond five, limit to thickness, round and
// saturate to Q8.12. Uses sffp_pkg widths.
module sffp_out #(
  parameter int FRAC_BITS = sffp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [sffp_pkg::ACC_W-1:0]        tot_i,
  input  logic [sffp_pkg::FAC_W-1:0]        fac_i,
  input  logic                              above_i,
  input  logic [sffp_pkg::IN_W-1:0]         h_i,
  output logic                              out_valid,
  output logic signed [sffp_pkg::OUT_W-1:0] out_shear_factor
);

  localparam int AW = sffp_pkg::ACC_W;
  localparam int MW = AW + sffp_pkg::FAC_W;
  localparam int SH = sffp_pkg::INT_FRAC - FRAC_BITS;
  localparam int OW = sffp_pkg::OUT_W;

  logic [AW-1:0]        mag1;
  logic [MW-1:0]        prod;
  logic [AW-1:0]        sc;
  logic [AW-1:0]        v_nxt;
  logic                 vld1_r;
  logic [AW-1:0]        v1_r;
  logic [sffp_pkg::IN_W-1:0] h1_r;
  logic [AW-1:0]        hint;
  logic [AW-1:0]        vc;
  logic [AW-1:0]        mag2;
  logic [AW-1:0]        rnd;
  logic [OW-1:0]        res_nxt;
  logic                 vld2_r;
  logic [OW-1:0]        res_r;

  // Scale the value at five by the decay factor
  always_comb begin
    mag1  = tot_i[AW-1] ? AW'(-tot_i) : tot_i;
    prod  = MW'(mag1) * MW'(fac_i) + (MW'(1) << 19);
    sc    = AW'(prod >> 20);
    if (above_i) v_nxt = tot_i[AW-1] ? AW'(-sc) : sc;
    else         v_nxt = tot_i;
  end

  always_ff @(posedge clk) begin
    v1_r <= v_nxt;
    h1_r <= h_i;
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= vld_i;
  end

  // Limit to thickness, round half away from zero, saturate
  always_comb begin
    hint = AW'(h1_r) << SH;
    vc   = ($signed(v1_r) > $signed(hint)) ? hint : v1_r;
    mag2 = vc[AW-1] ? AW'(-vc) : vc;
    rnd  = (mag2 + (AW'(1) << (SH - 1))) >> SH;
    if (!vc[AW-1]) begin
      res_nxt = (rnd > AW'((1 << (OW - 1)) - 1)) ? {1'b0, {(OW-1){1'b1}}} : OW'(rnd);
    end else begin
      res_nxt = (rnd > AW'(1 << (OW - 1))) ? {1'b1, {(OW-1){1'b0}}} : OW'(-rnd);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
  end

  assign out_valid        = vld2_r;
  assign out_shear_factor = $signed(res_r);

endmodule

/* sv/sffp_checker.sv */
// Port-level checks for the shear flow factor block, bound to the top level.
// Depends on sffp_pkg for the latency.
module sffp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [sffp_pkg::IN_W-1:0]         in_film_thickness,
  input logic                              out_valid,
  input logic signed [sffp_pkg::OUT_W-1:0] out_shear_factor
);

  // Every request gives a result after the fixed latency
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(sffp_pkg::LATENCY) out_valid)
    else $error("request without result");

  // No result without a request
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, sffp_pkg::LATENCY))
    else $error("result without request");

  // Result never exceeds the thickness of its request
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shear_factor <=
      $signed({5'b00000, $past(in_film_thickness, sffp_pkg::LATENCY)}))
    else $error("result above thickness");

  // Busy only while reset is held
  a_busy: assert property (@(posedge clk) busy |-> !rst_n)
    else $error("busy outside reset");

endmodule

bind shear_flow_factor_poly sffp_checker u_sffp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_film_thickness (in_film_thickness),
  .out_valid         (out_valid),
  .out_shear_factor  (out_shear_factor)
);

/* tb/testbench.sv */
// Testbench for the shear flow factor block: directed and random thickness requests
// under several gamma settings, checked against a predictor kept in this file.
// Depends on shear_flow_factor_poly.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC      = 12;
  localparam int DEPTH     = 256;
  localparam int IFRAC     = 24;
  localparam int CYCLE_CAP = 400000;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [15:0]            in_film_thickness;
  logic                   cfg_we;
  logic [15:0]            cfg_wdata;
  logic                   out_valid;
  logic signed [20:0]     out_shear_factor;

  shear_flow_factor_poly uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_film_thickness(in_film_thickness), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_shear_factor(out_shear_factor)
  );

  // Predictor state
  longint            coef_q [2][6][6];
  longint unsigned   decay_rom [DEPTH+1];
  logic [15:0]       gamma_q;
  logic signed [20:0] factor_q [$];
  int                mismatches;
  int                cycles;
  bit                idle_gaps;

  longint raw_coef [2][6][6] = '{
    '{'{1036000000, 378100000, -129800000, -14770000, 7365000, -566800},
      '{-64'sd4050000000, 681700000, 3060000, -12890000, 511600, 0},
      '{64'sd9711000000, -1204000000, 90080000, 3367000, 0, 0},
      '{-64'sd13490000000, 663200000, -46410000, 0, 0, 0},
      '{64'sd10210000000, -109800000, 0, 0, 0, 0},
      '{-64'sd3194000000, 0, 0, 0, 0, 0}},
    '{'{140300000, 744800000, -274400000, 31410000, -593200, -70390},
      '{109800000, -203000000, 59160000, -4833000, 100600, 0},
      '{-104200000, 26890000, -5968000, 265600, 0, 0},
      '{28280000, -1413000, 191600, 0, 0, 0},
      '{-3105000, 21830, 0, 0, 0, 0},
      '{120300, 0, 0, 0, 0, 0}}
  };

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Build coefficient grid and decay table once
  function automatic void build_tables();
    longint n;
    longint unsigned xq, f, t;
    longint s;
    int e;
    for (int a = 0; a < 2; a++)
      for (int j = 0; j < 6; j++)
        for (int i = 0; i < 6; i++) begin
          n = raw_coef[a][j][i];
          if (n < 0) coef_q[a][j][i] = -(((-n) * (64'sd1 <<< IFRAC) + 500000000) / 1000000000);
          else       coef_q[a][j][i] = (n * (64'sd1 <<< IFRAC) + 500000000) / 1000000000;
        end
    for (int k = 0; k <= DEPTH; k++) begin
      xq = (64'(k) << 32) / 64'(DEPTH);
      f  = xq & ((64'd1 << 30) - 1);
      t  = 64'd1 << 30;
      s  = 64'sd1 <<< 30;
      e  = int'(xq >> 30);
      for (int m = 1; m <= 20; m++) begin
        t = ((t * f) >> 30) / 64'(m);
        if (m & 1) s = s - longint'(t);
        else       s = s + longint'(t);
      end
      if (s < 0) s = 0;
      while (e > 0) begin
        s = longint'((64'(s) * 64'd395007542 + (64'd1 << 29)) >> 30);
        e--;
      end
      decay_rom[k] = s;
    end
  endfunction

  function automatic longint clip40(longint v);
    longint lim;
    lim = (64'sd1 <<< 40) - 1;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint scale_round(longint a, longint unsigned x);
    longint unsigned m, p;
    m = (a < 0) ? -a : a;
    p = (m * x + (64'd1 << (FRAC - 1))) >> FRAC;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint horner2d(int sel, longint unsigned h, longint unsigned g);
    longint total, acc;
    total = 0;
    for (int j = 5; j >= 0; j--) begin
      acc = coef_q[sel][j][5-j];
      for (int i = 4 - j; i >= 0; i--) acc = clip40(coef_q[sel][j][i] + scale_round(acc, h));
      if (j == 5) total = acc;
      else        total = clip40(acc + scale_round(total, g));
    end
    return total;
  endfunction

  function automatic longint unsigned decay_q20(longint unsigned d);
    longint unsigned pos, idx, fr, a, b, v;
    pos = d * DEPTH;
    idx = pos >> (FRAC + 4);
    fr  = pos & ((64'd1 << (FRAC + 4)) - 1);
    if (idx >= DEPTH) return 0;
    a = decay_rom[idx];
    b = decay_rom[idx+1];
    v = (a >= b) ? a - (((a - b) * fr) >> (FRAC + 4)) : a + (((b - a) * fr) >> (FRAC + 4));
    return (v + (64'd1 << 9)) >> 10;
  endfunction

  function automatic logic signed [20:0] shear_factor_of(logic [15:0] thick);
    longint unsigned h, g, five, mag;
    longint v, p5, r;
    int sel;
    h    = thick;
    g    = gamma_q;
    five = 64'd5 << FRAC;
    sel  = (g >= (64'd1 << FRAC)) ? 1 : 0;
    if (h > five) begin
      p5  = horner2d(sel, five, g);
      mag = (p5 < 0) ? -p5 : p5;
      mag = (mag * decay_q20(h - five) + (64'd1 << 19)) >> 20;
      v   = (p5 < 0) ? -longint'(mag) : longint'(mag);
    end else begin
      v = horner2d(sel, h, g);
    end
    if (v > longint'(h << (IFRAC - FRAC))) v = longint'(h << (IFRAC - FRAC));
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (IFRAC - FRAC - 1))) >> (IFRAC - FRAC);
    r   = (v < 0) ? -longint'(mag) : longint'(mag);
    if (r > 1048575) r = 1048575;
    if (r < -1048576) r = -1048576;
    return r[20:0];
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (factor_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %0d", out_shear_factor);
      end else begin
        if (out_shear_factor !== factor_q[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("shear_factor: expected %0d got %0d", factor_q[0], out_shear_factor);
        end
        void'(factor_q.pop_front());
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("shear_flow_factor_poly: mismatch");
      $finish;
    end
  end

  // Send one request, with an optional random gap first
  task automatic send_thickness(logic [15:0] thick);
    int gap;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_film_thickness <= thick;
    @(posedge clk);
    while (busy) @(posedge clk);
    factor_q.push_back(shear_factor_of(thick));
  endtask

  // Drain, settle, then write gamma
  task automatic set_gamma(logic [15:0] g);
    start <= 1'b0;
    @(posedge clk);
    while (factor_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we  <= 1'b0;
    gamma_q  = g;
  endtask

  task automatic test_thickness_extremes();
    logic [15:0] pts [12] = '{16'h0000, 16'h0001, 16'h0800, 16'h1000, 16'h4FFF, 16'h5000,
                              16'h5001, 16'h6000, 16'hAFFF, 16'hF000, 16'hFFFE, 16'hFFFF};
    foreach (pts[i]) send_thickness(pts[i]);
  endtask

  task automatic test_gamma_extremes();
    logic [15:0] gs [5] = '{16'h0000, 16'h0FFF, 16'h1000, 16'hFFFF, 16'h0001};
    foreach (gs[k]) begin
      set_gamma(gs[k]);
      send_thickness(16'h0000);
      send_thickness(16'h5000);
      send_thickness(16'h5001);
      send_thickness(16'hFFFF);
    end
  endtask

  task automatic test_random_phase(logic [15:0] g, int count);
    logic [15:0] h;
    set_gamma(g);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0:       h = 16'($urandom_range(0, 16'h5000));
        1:       h = 16'($urandom_range(16'h5000, 16'h5000 + 16'h0400));
        default: h = 16'($urandom);
      endcase
      send_thickness(h);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_film_thickness = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    mismatches = 0;
    cycles = 0;
    idle_gaps = 1'b1;
    gamma_q = 16'd4096;
    build_tables();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_thickness_extremes();
    test_gamma_extremes();
    for (int p = 0; p < 6; p++) test_random_phase(16'($urandom), 170);
    test_random_phase(16'h1000, 150);
    test_random_phase(16'($urandom_range(0, 16'h0FFF)), 150);
    idle_gaps = 1'b0;
    test_random_phase(16'($urandom_range(16'h1000, 16'h4000)), 200);
    start <= 1'b0;
    @(posedge clk);
    while (factor_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) $display("shear_flow_factor_poly: match");
    else $display("shear_flow_factor_poly: mismatch");
    $finish;
  end
endmodule
